@@ hdl/tgarle_pkg.sv @@
package tgarle_pkg;

	localparam int unsigned BPP_W         = 3;
	localparam int unsigned PIX_CNT_W     = 30;
	localparam int unsigned CFG_DATA_W    = 30;
	localparam int unsigned CFG_IDX_W     = 1;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BPP         = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_PIXEL_COUNT = 1'b1;

	localparam logic [BPP_W-1:0]     BPP_RESET   = 3'd3;
	localparam logic [BPP_W-1:0]     BPP_ALPHA   = 3'd4;
	localparam logic [PIX_CNT_W-1:0] PIX_CNT_RESET = 30'd1;

	localparam logic [7:0] RUN_BIAS = 8'd127;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	// byte plus its reading as a packet header
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       hdr_run;
		logic [7:0] hdr_len;
	} cls_item_t;

	typedef struct packed {
		logic [7:0]           blue;
		logic [7:0]           green;
		logic [7:0]           red;
		logic [7:0]           alpha;
		logic [7:0]           repeat_count;
		logic [PIX_CNT_W-1:0] first_index;
		logic                 last;
		logic                 error;
	} out_item_t;

endpackage

@@ hdl/tgarle_front.sv @@
module tgarle_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tgarle_pkg::in_item_t in_data,
	output logic                 push_valid,
	input  logic                 push_ready,
	output tgarle_pkg::cls_item_t push_data
);
	import tgarle_pkg::*;

	logic      valid_s1;
	cls_item_t item_s1;
	cls_item_t item_cls;

	always_comb begin
		item_cls.data_byte   = in_data.data_byte;
		item_cls.frame_start = in_data.frame_start;
		item_cls.hdr_run     = in_data.data_byte[7];
		// raw: header+1 pixels, run: header-127 copies
		if (in_data.data_byte[7]) begin
			item_cls.hdr_len = in_data.data_byte - RUN_BIAS;
		end else begin
			item_cls.hdr_len = in_data.data_byte + 8'd1;
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_cls;
		end
	end

endmodule

@@ hdl/tgarle_queue.sv @@
module tgarle_queue #(
	parameter int unsigned DEPTH = tgarle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  tgarle_pkg::cls_item_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output tgarle_pkg::cls_item_t pop_data
);
	import tgarle_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cls_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/tgarle_back.sv @@
module tgarle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  tgarle_pkg::cls_item_t pop_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tgarle_pkg::out_item_t out_data
);
	import tgarle_pkg::*;

	logic [BPP_W-1:0]     bpp_q;
	logic [PIX_CNT_W-1:0] pix_count_q;

	phase_t               phase_q;
	phase_t               phase_d;
	logic [7:0]           packet_left_q;
	logic [7:0]           packet_left_d;
	logic                 is_run_q;
	logic                 is_run_d;
	logic [1:0]           byte_pos_q;
	logic [1:0]           byte_pos_d;
	logic [7:0]           pix_byte_q [3];
	logic [PIX_CNT_W-1:0] done_q;
	logic [PIX_CNT_W-1:0] done_d;

	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 take;
	phase_t               phase_eff;
	logic [PIX_CNT_W-1:0] done_eff;
	logic                 bpp4;
	logic                 pix_end;
	logic                 store_en;
	logic [1:0]           store_idx;
	logic [7:0]           count;
	logic [7:0]           left_after;
	logic [PIX_CNT_W-1:0] limit;
	logic [PIX_CNT_W-1:0] remaining;
	logic                 fills;
	logic [7:0]           rep;
	logic                 emit;
	out_item_t            res;

	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q       <= BPP_RESET;
			pix_count_q <= PIX_CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_BPP:         bpp_q <= cfg_data[BPP_W-1:0];
				CFG_IDX_PIXEL_COUNT: pix_count_q <= cfg_data[PIX_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_eff  = pop_data.frame_start ? PH_HEADER : phase_q;
		done_eff   = pop_data.frame_start ? '0 : done_q;
		bpp4       = bpp_q == BPP_ALPHA;
		pix_end    = bpp4 ? (byte_pos_q == 2'd3) : (byte_pos_q >= 2'd2);
		store_idx  = (byte_pos_q == 2'd3) ? 2'd0 : byte_pos_q;
		count      = is_run_q ? packet_left_q : 8'd1;
		left_after = is_run_q ? 8'd0 : packet_left_q - 8'd1;
		limit      = (pix_count_q == '0) ? PIX_CNT_W'(1) : pix_count_q;
		remaining  = (done_eff < limit) ? limit - done_eff : '0;
		fills      = {{(PIX_CNT_W-8){1'b0}}, count} >= remaining;
		// clipped count is at most the packet length, so it fits in a byte
		rep        = fills ? remaining[7:0] : count;

		res.blue         = pix_byte_q[0];
		res.green        = pix_byte_q[1];
		res.red          = bpp4 ? pix_byte_q[2] : pop_data.data_byte;
		res.alpha        = bpp4 ? pop_data.data_byte : 8'd0;
		res.repeat_count = rep;
		res.first_index  = done_eff;
		res.last         = fills;
		res.error        = fills && (({{(PIX_CNT_W-8){1'b0}}, count} > remaining)
			|| (left_after != 8'd0));

		phase_d       = phase_q;
		packet_left_d = packet_left_q;
		is_run_d      = is_run_q;
		byte_pos_d    = byte_pos_q;
		done_d        = done_eff;
		store_en      = 1'b0;
		emit          = 1'b0;

		case (phase_eff)
			PH_HEADER: begin
				is_run_d      = pop_data.hdr_run;
				packet_left_d = pop_data.hdr_len;
				byte_pos_d    = 2'd0;
				phase_d       = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (!pix_end) begin
					store_en   = 1'b1;
					byte_pos_d = byte_pos_q + 2'd1;
				end else begin
					emit       = 1'b1;
					byte_pos_d = 2'd0;
					done_d     = done_eff + {{(PIX_CNT_W-8){1'b0}}, rep};
					if (fills) begin
						phase_d = PH_HALT;
					end else begin
						packet_left_d = left_after;
						if (left_after == 8'd0) begin
							phase_d = PH_HEADER;
						end
					end
				end
			end
			PH_HALT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			packet_left_q <= '0;
			is_run_q      <= 1'b0;
			byte_pos_q    <= '0;
			done_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				phase_q       <= phase_d;
				packet_left_q <= packet_left_d;
				is_run_q      <= is_run_d;
				byte_pos_q    <= byte_pos_d;
				done_q        <= done_d;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && store_en) begin
			pix_byte_q[store_idx] <= pop_data.data_byte;
		end
		if (take && emit) begin
			out_q <= res;
		end
	end

endmodule

@@ hdl/tga_rle_pixel_decoder_top.sv @@
// targa run-length pixel decoder
// input channel (in_valid/in_ready/in_data): one byte of the compressed stream per
// transaction; frame_start set on the first packet header of a frame clears the decoder
// output channel (out_valid/out_ready/out_data): one transaction per finished pixel
// with colour, repeat count, first pixel index, last and error; runs leave as one
// transaction and are expanded downstream
// config port: cfg_we with cfg_index 0 writes bytes per pixel, 1 writes pixel count
// throughput is one byte per cycle unless the receiver stalls the output
// an accepted byte passes the front register and a queue slot, and the result it
// finishes is held in the output register
// after reset: 3 bytes per pixel, pixel count 1, expecting a packet header
// when the receiver stalls the output register holds, the back end stops popping,
// the queue fills and in_ready falls only once front register and queue are full
// after a result with last set, bytes are dropped until one with frame_start arrives
module tga_rle_pixel_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = tgarle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tgarle_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tgarle_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tgarle_pkg::*;

	logic      push_valid;
	logic      push_ready;
	cls_item_t push_data;
	logic      pop_valid;
	logic      pop_ready;
	cls_item_t pop_data;

	tgarle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tgarle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tgarle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ bench/tb_tga_rle_pixel_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_top;
	import tgarle_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	tga_rle_pixel_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// byte stream waiting to be driven, pixels still owed by the decoder
	in_item_t  stream_bytes[$];
	out_item_t pending_pixels[$];

	// mirror of the register file
	logic [BPP_W-1:0]     cfg_bpp;
	logic [PIX_CNT_W-1:0] cfg_count;

	// mirror of the decoder state
	phase_t      dec_phase;
	int unsigned run_left;
	logic        in_run;
	int unsigned byte_pos;
	logic [7:0]  pix_store [3];
	int unsigned pix_done;

	int          fail_count  = 0;
	int          pixels_seen = 0;
	int          burst_left;
	int          gap_left;
	logic [15:0] ready_pat;
	int          pat_age;
	out_item_t   want_px;

	task automatic report(input string msg);
		fail_count++;
		$display("%0t %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [29:0] got,
			input logic [29:0] want);
		if (got !== want)
			report($sformatf("pixel %0d %s: got %0h, expected %0h", pixels_seen, name,
				got, want));
	endtask

	function automatic in_item_t make_item(input logic fs, input logic [7:0] b);
		in_item_t it;
		it.data_byte   = b;
		it.frame_start = fs;
		return it;
	endfunction

	function automatic void send(input logic fs, input logic [7:0] b);
		stream_bytes.push_back(make_item(fs, b));
	endfunction

	function automatic void clear_decoder();
		dec_phase = PH_HEADER;
		run_left  = 0;
		in_run    = 1'b0;
		byte_pos  = 0;
		pix_done  = 0;
	endfunction

	// one accepted byte of the stream; queues the pixel it finishes, if any
	task automatic decode_byte(input in_item_t it);
		int unsigned bpp_n, count, left_after, limit, remaining, rep;
		out_item_t   px;
		if (it.frame_start)
			clear_decoder();
		case (dec_phase)
			PH_HEADER: begin
				in_run    = it.data_byte[7];
				run_left  = in_run ? int'(it.data_byte) - int'(RUN_BIAS)
				                   : int'(it.data_byte) + 1;
				byte_pos  = 0;
				dec_phase = PH_PIXEL;
			end
			PH_PIXEL: begin
				bpp_n = (cfg_bpp == BPP_ALPHA) ? BPP_ALPHA : BPP_RESET;
				if (byte_pos < bpp_n - 1) begin
					pix_store[byte_pos] = it.data_byte;
					byte_pos++;
				end else begin
					px.blue        = pix_store[0];
					px.green       = pix_store[1];
					px.red         = (bpp_n == BPP_ALPHA) ? pix_store[2] : it.data_byte;
					px.alpha       = (bpp_n == BPP_ALPHA) ? it.data_byte : 8'h00;
					px.first_index = pix_done[29:0];
					byte_pos       = 0;
					count      = in_run ? run_left : 1;
					left_after = in_run ? 0 : run_left - 1;
					limit      = (cfg_count == 0) ? 1 : cfg_count;
					remaining  = (pix_done < limit) ? limit - pix_done : 0;
					if (count >= remaining) begin
						// frame filled: clip, flag any surplus, then halt
						rep       = remaining;
						px.last   = 1'b1;
						px.error  = (count > remaining) || (left_after > 0);
						dec_phase = PH_HALT;
					end else begin
						rep      = count;
						px.last  = 1'b0;
						px.error = 1'b0;
						if (left_after == 0)
							dec_phase = PH_HEADER;
						run_left = left_after;
					end
					pix_done        = pix_done + rep;
					px.repeat_count = rep[7:0];
					pending_pixels.push_back(px);
				end
			end
			default: ;
		endcase
	endtask

	// one frame of packets with random content, sometimes overrunning or cut short
	function automatic int queue_frame();
		in_item_t    frame_q[$];
		int unsigned pbytes, eff_count, target, covered, want_left, lim, n, cut, extra;
		logic        first;
		logic        over;
		pbytes    = (cfg_bpp == BPP_ALPHA) ? BPP_ALPHA : BPP_RESET;
		eff_count = (cfg_count == 0) ? 1 : cfg_count;
		target    = (eff_count > 200) ? 200 : eff_count;
		covered   = 0;
		first     = 1'b1;
		while (covered < target) begin
			want_left = target - covered;
			lim       = (want_left < 128) ? want_left : 128;
			over      = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 1)) begin
				n = over ? $urandom_range(lim, 128) : $urandom_range(1, lim);
				frame_q.push_back(make_item(first, 8'(n) + RUN_BIAS));
				repeat (pbytes) frame_q.push_back(make_item(1'b0, 8'($urandom)));
			end else begin
				if (over) begin
					n = lim + $urandom_range(0, 3);
					if (n > 128)
						n = 128;
				end else begin
					n = $urandom_range(1, (lim < 6) ? lim : 6);
				end
				frame_q.push_back(make_item(first, 8'(n - 1)));
				repeat (n * pbytes) frame_q.push_back(make_item(1'b0, 8'($urandom)));
			end
			first   = 1'b0;
			covered += n;
		end
		cut = frame_q.size();
		if (eff_count > 200 || $urandom_range(0, 4) == 0)
			cut = $urandom_range(1, (cut < 80) ? cut : 80);
		for (int i = 0; i < cut; i++)
			stream_bytes.push_back(frame_q[i]);
		// loose bytes: dropped when halted, otherwise they carry on the frame
		extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (extra) send(1'b0, 8'($urandom));
		return cut + extra;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_BPP)
			cfg_bpp = val[BPP_W-1:0];
		else
			cfg_count = val[PIX_CNT_W-1:0];
	endtask

	// decoder idle: everything sent and answered, plus slack for byte-only work
	task automatic settle();
		while (stream_bytes.size() != 0 || in_valid || pending_pixels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// driver: bursts of transactions with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || stream_bytes.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data  <= stream_bytes.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// monitor: checks each pixel transaction, stalls on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_pat = 16'hFFFF;
			pat_age   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					report($sformatf("unexpected pixel transaction %0d", pixels_seen));
				end else begin
					want_px = pending_pixels.pop_front();
					compare_field("blue", out_data.blue, want_px.blue);
					compare_field("green", out_data.green, want_px.green);
					compare_field("red", out_data.red, want_px.red);
					compare_field("alpha", out_data.alpha, want_px.alpha);
					compare_field("repeat_count", out_data.repeat_count,
						want_px.repeat_count);
					compare_field("first_index", out_data.first_index,
						want_px.first_index);
					compare_field("last", out_data.last, want_px.last);
					compare_field("error", out_data.error, want_px.error);
				end
				pixels_seen++;
			end
			out_ready <= ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[15:1]};
			pat_age++;
			if (pat_age >= 48) begin
				pat_age = $urandom_range(0, 40);
				case ($urandom_range(0, 3))
					0:       ready_pat = 16'hFFFF;
					1:       ready_pat = 16'($urandom);
					2:       ready_pat = 16'h0001 << $urandom_range(0, 15);
					default: ready_pat = 16'($urandom) | 16'($urandom);
				endcase
			end
		end
	end

	initial begin
		#400000;
		$display("tga_rle_pixel_decoder_top: mismatch");
		$finish;
	end

	initial begin
		int              rand_items;
		int              n;
		int              drain;
		int              r;
		logic [CFG_DATA_W-1:0] val;
		cfg_bpp   = BPP_RESET;
		cfg_count = PIX_CNT_RESET;
		clear_decoder();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one-pixel frame: raw packet of 128 and run of 128 both overrun, byte while halted
		send(1'b1, 8'h7F);
		send(1'b0, 8'h00);
		send(1'b0, 8'hFF);
		send(1'b0, 8'h80);
		send(1'b0, 8'hAA);
		send(1'b1, 8'hFF);
		send(1'b0, 8'h01);
		send(1'b0, 8'h02);
		send(1'b0, 8'h03);
		settle();

		// odd pixel size acts as three bytes, zero count acts as one
		write_reg(CFG_IDX_BPP, 30'd7);
		write_reg(CFG_IDX_PIXEL_COUNT, 30'd0);
		send(1'b1, 8'h00);
		send(1'b0, 8'h3C);
		send(1'b0, 8'hC3);
		send(1'b0, 8'h7F);
		settle();

		// bgra; frame start drops a raw packet, then leave a pixel half read
		write_reg(CFG_IDX_BPP, 30'(BPP_ALPHA));
		write_reg(CFG_IDX_PIXEL_COUNT, 30'd6);
		send(1'b1, 8'h05);
		send(1'b0, 8'h11);
		send(1'b1, 8'h83);
		send(1'b0, 8'hFF);
		send(1'b0, 8'h00);
		send(1'b0, 8'h80);
		send(1'b0, 8'h7F);
		send(1'b0, 8'h01);
		send(1'b0, 8'h22);
		send(1'b0, 8'h33);
		send(1'b0, 8'h44);
		settle();

		// shrink pixel size and count under the half-read pixel
		write_reg(CFG_IDX_BPP, 30'(BPP_RESET));
		write_reg(CFG_IDX_PIXEL_COUNT, 30'd2);
		send(1'b0, 8'h5A);
		settle();

		rand_items = 0;
		while (rand_items < 400) begin
			settle();
			if ($urandom_range(0, 3) != 0) begin
				r   = $urandom_range(0, 9);
				val = (r < 4) ? 30'(BPP_ALPHA) : (r < 8) ? 30'(BPP_RESET) : 30'($urandom_range(0, 7));
				write_reg(CFG_IDX_BPP, val);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 15))
					0:       val = 30'd0;
					1:       val = 30'd1;
					2:       val = 30'd1073676289;
					3:       val = '1;
					4:       val = 30'($urandom_range(41, 300));
					default: val = 30'($urandom_range(2, 24));
				endcase
				write_reg(CFG_IDX_PIXEL_COUNT, val);
			end
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(3, 10);
				repeat (n) send($urandom_range(0, 3) == 0, 8'($urandom));
				rand_items += n;
			end
			repeat ($urandom_range(1, 3)) rand_items += queue_frame();
		end

		while (stream_bytes.size() != 0 || in_valid)
			@(negedge clk);
		drain = 0;
		while (pending_pixels.size() != 0 && drain < 5000) begin
			@(negedge clk);
			drain++;
		end
		repeat (10) @(negedge clk);
		if (pending_pixels.size() != 0)
			report($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
		if (fail_count == 0)
			$display("tga_rle_pixel_decoder_top: match");
		else
			$display("tga_rle_pixel_decoder_top: mismatch");
		$finish;
	end

endmodule
